@@ design/oss_pkg.sv @@
// ----------------------------------------------------------------------------
// oss_pkg
// Shared widths and types for the order-statistic set.
// ----------------------------------------------------------------------------
`default_nettype none

package oss_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned KEY_W  = 31;
  localparam int unsigned RANK_W = 6;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned CMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_ERASE  = 1'b1
  } oss_cmd_e;

  // broadcast update to every cell of the row
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic [KEY_W-1:0] key;
  } oss_op_t;

endpackage

`default_nettype wire

@@ design/oss_in_if.sv @@
// ----------------------------------------------------------------------------
// oss_in_if
// Command channel: insert/erase a key and the rank to report.
// ----------------------------------------------------------------------------
`default_nettype none

interface oss_in_if;
  import oss_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [KEY_W-1:0]  key;
  logic [RANK_W-1:0] rank;

  modport source (output valid, command, key, rank, input ready);
  modport sink   (input valid, command, key, rank, output ready);
endinterface

`default_nettype wire

@@ design/oss_out_if.sv @@
// ----------------------------------------------------------------------------
// oss_out_if
// Result channel: key at the requested rank and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface oss_out_if;
  import oss_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] selected_key;
  logic             selected_valid;
  logic             insert_dropped;

  modport source (output valid, selected_key, selected_valid, insert_dropped, input ready);
  modport sink   (input valid, selected_key, selected_valid, insert_dropped, output ready);
endinterface

`default_nettype wire

@@ design/oss_cell.sv @@
// ----------------------------------------------------------------------------
// oss_cell
// One slot of the sorted row: compares its key and shifts on insert/erase.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_cell (
  input  wire logic                     clk_i,
  input  wire oss_pkg::oss_op_t         op_i,
  input  wire logic                     occ_i,
  input  wire logic                     left_lt_i,
  input  wire logic [oss_pkg::KEY_W-1:0] left_key_i,
  input  wire logic [oss_pkg::KEY_W-1:0] right_key_i,
  output logic                          lt_o,
  output logic                          eq_o,
  output logic [oss_pkg::KEY_W-1:0]     key_o
);
  import oss_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;

  assign lt_o  = occ_i && (key_q < op_i.key);
  assign eq_o  = occ_i && (key_q == op_i.key);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (op_i.ins_en && !lt_o) begin
      key_d = left_lt_i ? op_i.key : left_key_i;
    end else if (op_i.del_en && !lt_o) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

@@ design/order_statistic_set.sv @@
// ----------------------------------------------------------------------------
// order_statistic_set
// Sorted set of distinct keys with rank lookup, built as a row of cells.
//
// in_i carries command (insert or erase), key and rank; out_o returns the key
// at that rank after the update, its valid flag and the insert-dropped flag.
// Every cell compares its key with the incoming key in parallel; on a
// transfer the row shifts right (insert) or left (erase) behind the key's
// position. The rank is then read from the row, while the item waits in the
// lookup stage, by a CAPACITY-to-one multiplexer into the output register.
// Throughput: one item per cycle while the receiver keeps taking results.
// When the receiver stalls, one item waits in the lookup stage and one in the
// output register; in_i.ready then drops until the output drains.
// Reset empties the set (count zero) and clears both stages; stored keys are
// not cleared and are never read beyond the count.
// ----------------------------------------------------------------------------
`default_nettype none

module order_statistic_set (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  oss_in_if.sink    in_i,
  oss_out_if.source out_o
);
  import oss_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CAPACITY-1:0] occ, lt, eq, left_lt;
  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic [KEY_W-1:0] left_key [CAPACITY];
  logic [KEY_W-1:0] right_key [CAPACITY];
  oss_op_t op;
  logic present, full, accept, a_take;

  logic              a_valid_q;
  logic [RANK_W-1:0] a_rank_q;
  logic              a_drop_q;
  logic              a_sel_valid;
  logic [KEY_W-1:0]  a_sel_key;

  logic             b_valid_q;
  logic [KEY_W-1:0] b_key_q;
  logic             b_sel_q;
  logic             b_drop_q;

  assign present = |eq;
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign a_take  = !b_valid_q || out_o.ready;
  assign in_i.ready = !a_valid_q || a_take;
  assign accept  = in_i.valid && in_i.ready;

  assign op.ins_en = accept && (in_i.command == CMD_INSERT) && !present && !full;
  assign op.del_en = accept && (in_i.command == CMD_ERASE) && present;
  assign op.key    = in_i.key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_q);
    if (i == 0) begin : g_first
      assign left_lt[i]  = 1'b1;
      assign left_key[i] = '0;
    end else begin : g_mid
      assign left_lt[i]  = lt[i-1];
      assign left_key[i] = cell_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key[i] = '0;
    end else begin : g_inner
      assign right_key[i] = cell_key[i+1];
    end

    oss_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .occ_i       (occ[i]),
      .left_lt_i   (left_lt[i]),
      .left_key_i  (left_key[i]),
      .right_key_i (right_key[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i]),
      .key_o       (cell_key[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (op.ins_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (op.del_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // lookup on the row as left by the item in the lookup stage
  assign a_sel_valid = (CMP_W'(a_rank_q) < CMP_W'(count_q));
  assign a_sel_key   = a_sel_valid ? cell_key[IDX_W'(a_rank_q)] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_i.ready) begin
        a_valid_q <= accept;
      end
      if (a_take) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_rank_q <= in_i.rank;
      a_drop_q <= (in_i.command == CMD_INSERT) && !present && full;
    end
    if (a_take && a_valid_q) begin
      b_key_q  <= a_sel_key;
      b_sel_q  <= a_sel_valid;
      b_drop_q <= a_drop_q;
    end
  end

  assign out_o.valid          = b_valid_q;
  assign out_o.selected_key   = b_key_q;
  assign out_o.selected_valid = b_sel_q;
  assign out_o.insert_dropped = b_drop_q;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for order_statistic_set.
// Directed items cover the empty set, extreme keys, duplicates, absent erases,
// out-of-range ranks and a full set. Long random insert/erase runs follow,
// with random keys and ranks. Source gaps and sink stalls vary by phase. Each
// accepted command is predicted against a sorted key queue, and each result
// transfer is checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import oss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             valid;
    logic             dropped;
  } rank_result_t;

  logic clk = 1'b0;
  logic rst_ni;

  oss_in_if  in_ch ();
  oss_out_if out_ch ();

  order_statistic_set dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk = ~clk;

  logic [KEY_W-1:0] set_keys[$];      // ascending, mirrors the block's contents
  rank_result_t     pending_ranks[$];
  int unsigned      mismatch_cnt = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      src_idle_pct = 0;
  int unsigned      snk_stall_pct = 0;

  // apply one command to the mirror set and return the expected result
  function automatic rank_result_t predict_rank(oss_cmd_e cmd, logic [KEY_W-1:0] key,
                                                logic [RANK_W-1:0] rank);
    int unsigned  pos;
    bit           found;
    rank_result_t res;
    pos = 0;
    while (pos < set_keys.size() && set_keys[pos] < key) pos++;
    found = (pos < set_keys.size()) && (set_keys[pos] == key);
    res = '0;
    if (cmd == CMD_INSERT) begin
      if (!found) begin
        if (set_keys.size() >= CAPACITY) res.dropped = 1'b1;
        else set_keys.insert(pos, key);
      end
    end else if (found) begin
      set_keys.delete(pos);
    end
    if (rank < set_keys.size()) begin
      res.key   = set_keys[rank];
      res.valid = 1'b1;
    end
    return res;
  endfunction

  // command transfers first, then result transfers
  always @(posedge clk) begin
    rank_result_t exp_res;
    bit           accepted;
    accepted = 1'b0;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      pending_ranks.push_back(predict_rank(oss_cmd_e'(in_ch.command), in_ch.key, in_ch.rank));
      accepted = 1'b1;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      accepted = 1'b1;
      if (pending_ranks.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result with nothing expected: key %h valid %b dropped %b", $realtime,
                   out_ch.selected_key, out_ch.selected_valid, out_ch.insert_dropped);
      end else begin
        exp_res = pending_ranks.pop_front();
        if (out_ch.selected_key !== exp_res.key || out_ch.selected_valid !== exp_res.valid ||
            out_ch.insert_dropped !== exp_res.dropped) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"%0t: mismatch: expected key %h valid %b dropped %b, ",
                      "got key %h valid %b dropped %b"},
                     $realtime, exp_res.key, exp_res.valid, exp_res.dropped,
                     out_ch.selected_key, out_ch.selected_valid, out_ch.insert_dropped);
        end
      end
    end
    if (accepted) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("order_statistic_set verification failed");
      $finish;
    end
  end

  // sink side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // entered just after a rising edge; leaves valid high after the transfer
  task automatic send_item(oss_cmd_e cmd, logic [KEY_W-1:0] key, logic [RANK_W-1:0] rank);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= key;
    in_ch.rank    <= rank;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_set();
    send_item(CMD_ERASE, '0, '0);
    send_item(CMD_ERASE, {KEY_W{1'b1}}, {RANK_W{1'b1}});
  endtask

  task automatic test_extreme_keys();
    send_item(CMD_INSERT, '0, '0);
    send_item(CMD_INSERT, {KEY_W{1'b1}}, 6'd1);
    send_item(CMD_INSERT, {KEY_W{1'b1}}, 6'd1);           // duplicate
    send_item(CMD_INSERT, 31'h2AAA_AAAA, 6'd1);
    send_item(CMD_INSERT, 31'h5555_5555, 6'd2);
    send_item(CMD_INSERT, 31'h0000_0001, {RANK_W{1'b1}}); // rank beyond count
    send_item(CMD_INSERT, 31'h0000_0001, 6'd1);
    send_item(CMD_ERASE, 31'h1234_5678, 6'd0);            // absent
    send_item(CMD_ERASE, '0, 6'd0);
    send_item(CMD_ERASE, {KEY_W{1'b1}}, 6'd3);
    send_item(CMD_ERASE, 31'h0000_0001, 6'd2);
    send_item(CMD_ERASE, 31'h2AAA_AAAA, 6'd0);
    send_item(CMD_ERASE, 31'h5555_5555, 6'd0);            // set empty again
  endtask

  task automatic test_full_set();
    logic [KEY_W-1:0] stale[$];
    bit               used[logic [KEY_W-1:0]];
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] first_k;
    wait_drained();
    stale = set_keys;
    first_k = '0;
    foreach (stale[i]) send_item(CMD_ERASE, stale[i], 6'($urandom_range(63)));
    for (int i = 0; i < CAPACITY + 4; i++) begin
      do k = KEY_W'($urandom()); while (used.exists(k));
      used[k] = 1'b1;
      if (i == 0) first_k = k;
      send_item(CMD_INSERT, k, (i % 2) ? {RANK_W{1'b1}} : RANK_W'(i));
    end
    send_item(CMD_INSERT, first_k, {RANK_W{1'b1}});        // duplicate while full
    wait_drained();
    send_item(CMD_ERASE, set_keys[CAPACITY/2], 6'd0);
    do k = KEY_W'($urandom()); while (used.exists(k));
    send_item(CMD_INSERT, k, {RANK_W{1'b1}});
    send_item(CMD_INSERT, k ^ 31'h1, 6'd0);                  // full again or duplicate
  endtask

  task automatic test_random_churn(int unsigned n, int unsigned insert_pct);
    int unsigned      sel;
    int unsigned      sz;
    logic [KEY_W-1:0] k;
    logic [RANK_W-1:0] r;
    oss_cmd_e         cmd;
    repeat (n) begin
      sz  = set_keys.size();
      cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_ERASE;
      sel = $urandom_range(99);
      if (sel < 45 && sz > 0) k = set_keys[$urandom_range(sz - 1)];
      else if (sel < 70) k = KEY_W'($urandom_range(31));
      else k = KEY_W'($urandom());
      if ($urandom_range(99) < 65) r = RANK_W'($urandom_range((sz < 63) ? sz : 63));
      else r = RANK_W'($urandom_range(63));
      send_item(cmd, k, r);
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_INSERT;
    in_ch.key     = '0;
    in_ch.rank    = '0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(posedge clk);

    test_empty_set();
    test_extreme_keys();
    test_full_set();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 37; snk_stall_pct = 37; end
      endcase
      test_random_churn(85, 80);
      test_random_churn(85, 30);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_ranks.size() == 0) begin
      $display("order_statistic_set verification clean");
    end else begin
      $display("order_statistic_set verification failed");
    end
    $finish;
  end

endmodule
